// ----- design/http_request_line_checker_macros.svh -----
// Assertion macros for the request line checker.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef HTTP_REQUEST_LINE_CHECKER_MACROS_SVH
`define HTTP_REQUEST_LINE_CHECKER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property that must hold at every clock edge outside reset
`define HRLC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition in this cycle implies a consequence in the next cycle
`define HRLC_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`else

`define HRLC_ASSERT(label, prop, msg)

`define HRLC_ASSERT_NEXT(label, cond, conseq, msg)

`endif

`endif

// ----- design/hrlc_pkg.sv -----
`timescale 1ns / 1ps

package hrlc_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int LEN_WIDTH   = 16;
    localparam int BAL_WIDTH   = 17;
    localparam int NUM_METHODS = 5;

    typedef enum logic [1:0] {
        PH_METHOD,
        PH_URI,
        PH_VERSION,
        PH_DONE
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK,
        ST_BAD,
        ST_NOTIMPL,
        ST_FORBID,
        ST_LONG,
        ST_VERSION
    } status_t;

    typedef enum logic [2:0] {
        M_GET,
        M_POST,
        M_PUT,
        M_HEAD,
        M_DELETE
    } method_t;

    // Register map: word index taken from paddr[2]
    localparam logic REG_URI_LIMIT = 1'b0;
    localparam logic [15:0] URI_LIMIT_RESET = 16'd8192;

    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_QMARK = 8'h3F;

    localparam logic [3:0] TPOS_MAX = 4'd15;
    localparam logic [3:0] VER_LEN  = 4'd8;

    localparam logic signed [BAL_WIDTH-1:0] BAL_MIN = {1'b1, {(BAL_WIDTH-1){1'b0}}};
    localparam logic signed [BAL_WIDTH-1:0] BAL_MAX = {1'b0, {(BAL_WIDTH-1){1'b1}}};

    localparam logic [3:0] METH_LEN [NUM_METHODS] = '{4'd3, 4'd4, 4'd3, 4'd4, 4'd6};

    localparam logic [7:0] METH_TXT [NUM_METHODS][8] = '{
        '{"G", "E", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"P", "O", "S", "T", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"P", "U", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"H", "E", "A", "D", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"D", "E", "L", "E", "T", "E", 8'h00, 8'h00}
    };

    localparam logic [7:0] VER_TXT [8] = '{"H", "T", "T", "P", "/", "1", ".", "1"};

    // Parser state carried from byte to byte
    typedef struct packed {
        phase_t                        phase;
        status_t                       err;
        logic [NUM_METHODS-1:0]        cand;
        logic [3:0]                    tpos;
        logic [COUNT_WIDTH-1:0]        ulen;
        logic [COUNT_WIDTH-1:0]        qpos;
        logic                          qseen;
        logic signed [BAL_WIDTH-1:0]   bal;
        logic                          seg_open;
        logic                          prev_dot;
        logic                          seg_dd;
        logic                          ver_bad;
        logic                          prev_cr;
        logic                          last_slash;
    } parse_t;

    localparam parse_t PARSE_CLEAR = '{
        phase:      PH_METHOD,
        err:        ST_OK,
        cand:       {NUM_METHODS{1'b1}},
        tpos:       4'd0,
        ulen:       {COUNT_WIDTH{1'b0}},
        qpos:       {COUNT_WIDTH{1'b0}},
        qseen:      1'b0,
        bal:        {BAL_WIDTH{1'b0}},
        seg_open:   1'b0,
        prev_dot:   1'b0,
        seg_dd:     1'b0,
        ver_bad:    1'b0,
        prev_cr:    1'b0,
        last_slash: 1'b0
    };

    // Saturating token position advance
    function automatic logic [3:0] bump_pos(input logic [3:0] pos);
        return (pos != TPOS_MAX) ? pos + 4'd1 : pos;
    endfunction

    // Close one segment: dot-dot segments count down, others up, both saturating
    function automatic logic signed [BAL_WIDTH-1:0] count_seg(
        input logic signed [BAL_WIDTH-1:0] bal,
        input logic                        dotdot
    );
        logic signed [BAL_WIDTH-1:0] r;
        r = bal;
        if (dotdot)
        begin
            if (bal != BAL_MIN)
                r = bal - {{(BAL_WIDTH-1){1'b0}}, 1'b1};
        end
        else if (bal != BAL_MAX)
        begin
            r = bal + {{(BAL_WIDTH-1){1'b0}}, 1'b1};
        end
        return r;
    endfunction

    // Cap a length at the output field width
    function automatic logic [LEN_WIDTH-1:0] cap_len(input logic [31:0] v);
        return (v > 32'({LEN_WIDTH{1'b1}})) ? {LEN_WIDTH{1'b1}} : v[LEN_WIDTH-1:0];
    endfunction

    // Take one line byte into the parser state
    function automatic parse_t feed(
        input parse_t      s,
        input logic [7:0]  b,
        input logic [15:0] limit
    );
        parse_t                 n;
        logic [NUM_METHODS-1:0] hit;
        n   = s;
        hit = '0;
        if (s.err == ST_OK)
        begin
            unique case (s.phase)
                PH_METHOD:
                begin
                    if (b == CH_SP)
                    begin
                        for (int i = 0; i < NUM_METHODS; i++)
                        begin
                            if (s.cand[i] && METH_LEN[i] == s.tpos)
                                hit[i] = 1'b1;
                        end
                        if (s.tpos == 4'd0)
                            n.err = ST_BAD;
                        else if (hit == '0)
                            n.err = ST_NOTIMPL;
                        else
                        begin
                            n.cand  = hit;
                            n.phase = PH_URI;
                            n.tpos  = 4'd0;
                        end
                    end
                    else
                    begin
                        for (int i = 0; i < NUM_METHODS; i++)
                        begin
                            if (s.tpos >= METH_LEN[i] || METH_TXT[i][s.tpos[2:0]] != b)
                                n.cand[i] = 1'b0;
                        end
                        n.tpos = bump_pos(s.tpos);
                    end
                end
                PH_URI:
                begin
                    if (b == CH_SP)
                    begin
                        if (s.ulen == '0)
                            n.err = ST_BAD;
                        else
                        begin
                            if (s.seg_open && !s.last_slash)
                                n.bal = count_seg(s.bal, s.seg_dd);
                            n.phase = PH_VERSION;
                            n.tpos  = 4'd0;
                            if (n.bal[BAL_WIDTH-1])
                                n.err = ST_FORBID;
                            else if (32'(s.ulen) >= 32'(limit))
                                n.err = ST_LONG;
                        end
                    end
                    else if (s.ulen == '0 && b != CH_SLASH)
                    begin
                        n.err = ST_BAD;
                    end
                    else
                    begin
                        if (b == CH_QMARK && !s.qseen)
                        begin
                            n.qseen = 1'b1;
                            n.qpos  = s.ulen;
                        end
                        if (b == CH_SLASH)
                        begin
                            if (s.seg_open)
                                n.bal = count_seg(s.bal, s.seg_dd);
                            n.seg_open   = 1'b1;
                            n.last_slash = 1'b1;
                            n.prev_dot   = 1'b0;
                            n.seg_dd     = 1'b0;
                        end
                        else
                        begin
                            n.last_slash = 1'b0;
                            if (b == CH_DOT)
                            begin
                                if (s.prev_dot)
                                    n.seg_dd = 1'b1;
                                n.prev_dot = 1'b1;
                            end
                            else
                            begin
                                n.prev_dot = 1'b0;
                            end
                        end
                        if (s.ulen != {COUNT_WIDTH{1'b1}})
                            n.ulen = s.ulen + 1'b1;
                    end
                end
                PH_VERSION:
                begin
                    if (s.tpos == 4'd0 && b == CH_SP)
                        n.err = ST_BAD;
                    else
                    begin
                        if (s.tpos >= VER_LEN || VER_TXT[s.tpos[2:0]] != b)
                            n.ver_bad = 1'b1;
                        n.tpos = bump_pos(s.tpos);
                    end
                end
                PH_DONE:
                begin
                end
            endcase
        end
        return n;
    endfunction

endpackage

// ----- design/http_request_line_checker.sv -----
// A result is registered and appears on the output in the cycle after the LF byte is accepted.
// Throughput: one byte per cycle; the parser state registers update in the
// accept cycle, and a held result stalls input only while out_ready is low.
// Reset (rst_n low, asynchronous): parser state cleared, no result pending,
// uri_limit back to 8192.
`timescale 1ns / 1ps

`include "http_request_line_checker_macros.svh"

module http_request_line_checker (
    input  logic                clk,
    input  logic                rst_n,
    // configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    // byte stream in
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          data_byte,
    input  logic                start_req,
    // result out
    output logic                out_valid,
    input  logic                out_ready,
    output hrlc_pkg::status_t   status,
    output hrlc_pkg::method_t   method,
    output logic [15:0]         path_length,
    output logic [15:0]         query_length
);

    import hrlc_pkg::*;

    logic [15:0]            uri_limit_reg;
    parse_t                 state_reg;
    parse_t                 state_next;
    parse_t                 cur;
    parse_t                 tmp;
    logic                   in_fire;
    logic                   line_end;
    logic                   apb_write;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    status_t                status_reg;
    status_t                status_next;
    method_t                method_reg;
    method_t                method_next;
    logic [LEN_WIDTH-1:0]   path_len_reg;
    logic [LEN_WIDTH-1:0]   path_len_next;
    logic [LEN_WIDTH-1:0]   query_len_reg;
    logic [LEN_WIDTH-1:0]   query_len_next;

    // Configuration register access
    assign pready    = 1'b1;
    assign apb_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            uri_limit_reg <= URI_LIMIT_RESET;
        else if (apb_write && paddr[2] == REG_URI_LIMIT)
            uri_limit_reg <= pwdata[15:0];
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_URI_LIMIT: prdata = {16'd0, uri_limit_reg};
            default:       prdata = 32'd0;
        endcase
    end

    // Accept a byte whenever the result slot is free or draining
    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    // Start of request clears the state before this byte is seen
    assign cur      = start_req ? PARSE_CLEAR : state_reg;
    assign line_end = (cur.phase != PH_DONE) && cur.prev_cr && (data_byte == CH_LF);

    // Next parser state
    always_comb
    begin
        state_next = state_reg;
        tmp        = cur;
        if (in_fire)
        begin
            if (cur.phase == PH_DONE)
            begin
                state_next = cur;
            end
            else if (line_end)
            begin
                state_next         = cur;
                state_next.phase   = PH_DONE;
                state_next.prev_cr = 1'b0;
            end
            else
            begin
                // A held CR not followed by LF is an ordinary line byte
                if (cur.prev_cr)
                begin
                    tmp         = feed(tmp, CH_CR, uri_limit_reg);
                    tmp.prev_cr = 1'b0;
                end
                if (data_byte == CH_CR)
                    tmp.prev_cr = 1'b1;
                else
                    tmp = feed(tmp, data_byte, uri_limit_reg);
                state_next = tmp;
            end
        end
    end

    // Result fields at end of line
    always_comb
    begin
        status_next    = cur.err;
        method_next    = M_GET;
        path_len_next  = '0;
        query_len_next = '0;
        if (cur.err == ST_OK)
        begin
            if (cur.phase != PH_VERSION)
                status_next = ST_BAD;
            else if (cur.ver_bad || cur.tpos != VER_LEN)
                status_next = ST_VERSION;
        end
        // lowest candidate wins
        if (cur.phase == PH_URI || cur.phase == PH_VERSION)
        begin
            for (int i = NUM_METHODS - 1; i >= 0; i--)
            begin
                if (cur.cand[i])
                    method_next = method_t'(3'(i));
            end
        end
        if (cur.phase == PH_VERSION)
        begin
            if (cur.qseen)
            begin
                path_len_next = cap_len(32'(cur.qpos));
                if (cur.ulen > cur.qpos)
                    query_len_next = cap_len(32'(cur.ulen - cur.qpos - 1'b1));
            end
            else
            begin
                path_len_next = cap_len(32'(cur.ulen));
            end
        end
    end

    // Result slot handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_fire)
            out_valid_next = line_end;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= PARSE_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Load the result payload on a line end transfer
    always_ff @(posedge clk)
    begin
        if (in_fire && line_end)
        begin
            status_reg    <= status_next;
            method_reg    <= method_next;
            path_len_reg  <= path_len_next;
            query_len_reg <= query_len_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign method       = method_reg;
    assign path_length  = path_len_reg;
    assign query_length = query_len_reg;

    // Checks
    `HRLC_ASSERT(a_result_after_lf, $rose(out_valid_reg) |-> $past(in_fire && data_byte == CH_LF), "result without an LF transfer")
    `HRLC_ASSERT_NEXT(a_done_after_line, in_fire && line_end, state_reg.phase == PH_DONE, "parser not done after line end")
    `HRLC_ASSERT(a_single_method, (state_reg.phase == PH_URI || state_reg.phase == PH_VERSION) |-> $onehot(state_reg.cand), "method candidates not one-hot past method token")

endmodule
